// ===== rtl/core/sefr_pkg.sv =====
`default_nettype none

package sefr_pkg;

    localparam int FRAME_LEN      = 16;
    // only frame bytes 8 to 14 are kept, byte 15 arrives with the last beat
    localparam int WIN_LEN        = 7;
    localparam int CNT_W          = $clog2(FRAME_LEN);

    localparam logic [15:0] TYPE_SYNC     = 16'h0000;
    localparam logic [15:0] TYPE_KEY      = 16'h0001;
    localparam logic [15:0] TYPE_ABS      = 16'h0003;
    localparam logic [15:0] CODE_TOUCH    = 16'h014a;
    localparam logic [15:0] CODE_PEN      = 16'h0140;
    localparam logic [15:0] CODE_PRESSURE = 16'h0018;
    localparam logic [15:0] CODE_X        = 16'h0000;
    localparam logic [15:0] CODE_Y        = 16'h0001;
    localparam logic [15:0] Y_MIRROR      = 16'd20720;
    localparam logic [15:0] PRESSURE_MAX  = 16'd4095;
    localparam logic [15:0] PRESSURE_FLOOR = 16'd20;

    localparam logic [1:0] EV_SYNC = 2'd0;
    localparam logic [1:0] EV_KEY  = 2'd1;
    localparam logic [1:0] EV_ABS  = 2'd3;

    localparam int OFFSET_W = 12;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd400;

    // register index taken from paddr[2]
    localparam logic REG_PRESSURE_OFFSET = 1'b0;
    localparam logic REG_PRESSURE_ZERO   = 1'b1;
    localparam int   PADDR_W             = 3;

    localparam int DESC_DEPTH = 2;
    localparam int DESC_PTR_W = $clog2(DESC_DEPTH);
    localparam int DESC_CNT_W = $clog2(DESC_DEPTH + 1);

    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic [OFFSET_W-1:0] pressure_offset;
        logic                pressure_zero_mode;
    } cfg_t;

    // one classified frame
    typedef struct packed {
        logic        start;
        logic        pen_lift;
        logic        is_abs;
        logic [1:0]  etype;
        logic [15:0] code;
        logic [31:0] value;
    } desc_t;

    typedef struct packed {
        logic [1:0]  etype;
        logic [15:0] code;
        logic [31:0] value;
        logic        last;
    } event_t;

endpackage

`default_nettype wire

// ===== rtl/core/stylus_event_frame_remapper_top.sv =====
`default_nettype none

// channel   direction  handshake          beat contents
// byte in   in         push / full        rx_byte
// events    out        pop / empty        event_type, event_code, event_value, last_of_frame
// config    in         apb psel/penable   pressure_offset @0x0, pressure_zero_mode @0x4
//
// one byte beat per cycle unless full; a complete valid frame is classified in the cycle
// of its last byte and its one to four events leave the back end at one per cycle unless
// stalled; full rises only while the two-entry frame queue is occupied by stalled frames
// rst_n clears the byte count, the started flag and both queues and resets the registers
// a stalled event pop backs up the output queue, then the frame queue, then push

module stylus_event_frame_remapper_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [7:0]                     rx_byte,
    input  wire logic                           pop,
    output logic                                empty,
    output logic [1:0]                          event_type,
    output logic [15:0]                         event_code,
    output logic signed [31:0]                  event_value,
    output logic                                last_of_frame,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sefr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import sefr_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   cfg_wr;
    logic   in_fire;
    desc_t  front_desc;
    desc_t  head_desc;
    logic   desc_push;
    logic   desc_pop;
    logic   desc_full;
    logic   desc_empty;
    event_t out_event;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_PRESSURE_OFFSET: cfg_next.pressure_offset = pwdata[OFFSET_W-1:0];
                REG_PRESSURE_ZERO:   cfg_next.pressure_zero_mode = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PRESSURE_OFFSET: prdata = {{(32-OFFSET_W){1'b0}}, cfg_reg.pressure_offset};
            REG_PRESSURE_ZERO:   prdata = {31'd0, cfg_reg.pressure_zero_mode};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressure_offset    <= OFFSET_RESET;
            cfg_reg.pressure_zero_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full    = desc_full;
    assign in_fire = push && !full;

    sefr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (rx_byte),
        .desc      (front_desc),
        .desc_push (desc_push)
    );

    sefr_desc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_data (front_desc),
        .rd_en   (desc_pop),
        .rd_data (head_desc),
        .q_full  (desc_full),
        .q_empty (desc_empty)
    );

    sefr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .desc       (head_desc),
        .desc_empty (desc_empty),
        .desc_pop   (desc_pop),
        .out_pop    (pop),
        .out_empty  (empty),
        .out_event  (out_event)
    );

    assign event_type    = out_event.etype;
    assign event_code    = out_event.code;
    assign event_value   = out_event.value;
    assign last_of_frame = out_event.last;

    a_no_desc_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |-> !desc_full)
        else $error("frame queue written while full");

    a_no_desc_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        desc_pop |-> !desc_empty)
        else $error("frame queue read while empty");

    a_push_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |-> (push && !full))
        else $error("frame classified without a byte beat");

endmodule

`default_nettype wire

// ===== rtl/core/sefr_front.sv =====
`default_nettype none

module sefr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_fire,
    input  wire logic [7:0]     rx_byte,
    output sefr_pkg::desc_t     desc,
    output logic                desc_push
);
    import sefr_pkg::*;

    logic [7:0]       win_reg [WIN_LEN];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             started_reg;
    logic             started_next;

    logic [15:0] frame_type;
    logic [15:0] frame_code;
    logic [31:0] frame_value;
    logic        complete;
    logic        type_ok;

    assign frame_type  = {win_reg[1], win_reg[0]};
    assign frame_code  = {win_reg[3], win_reg[2]};
    assign frame_value = {rx_byte, win_reg[6], win_reg[5], win_reg[4]};
    assign complete    = (cnt_reg == CNT_W'(FRAME_LEN - 1));
    assign type_ok     = (frame_type == TYPE_SYNC) || (frame_type == TYPE_KEY)
                         || (frame_type == TYPE_ABS);

    assign desc_push = in_fire && complete && type_ok;

    always_comb
    begin
        desc.start    = !started_reg;
        desc.pen_lift = (frame_type == TYPE_KEY) && (frame_code == CODE_PEN)
                        && (frame_value != 32'd1);
        desc.is_abs   = (frame_type == TYPE_ABS);
        desc.etype    = frame_type[1:0];
        desc.code     = frame_code;
        desc.value    = frame_value;
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        started_next = started_reg;
        if (in_fire)
        begin
            if (!complete)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else if (type_ok)
            begin
                cnt_next     = '0;
                started_next = 1'b1;
            end
            else
            begin
                // bad type: slide the window by one byte
                cnt_next = CNT_W'(FRAME_LEN - 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_LEN-1] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sefr_desc_queue.sv =====
`default_nettype none

module sefr_desc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  sefr_pkg::desc_t      wr_data,
    input  wire logic            rd_en,
    output sefr_pkg::desc_t      rd_data,
    output logic                 q_full,
    output logic                 q_empty
);
    import sefr_pkg::*;

    desc_t                 mem [DESC_DEPTH];
    logic [DESC_PTR_W-1:0] wr_ptr_reg;
    logic [DESC_PTR_W-1:0] rd_ptr_reg;
    logic [DESC_CNT_W-1:0] cnt_reg;
    logic [DESC_CNT_W-1:0] cnt_next;

    assign q_full  = (cnt_reg == DESC_CNT_W'(DESC_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + DESC_CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - DESC_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + DESC_PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + DESC_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sefr_back.sv =====
`default_nettype none

module sefr_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  sefr_pkg::cfg_t    cfg,
    input  sefr_pkg::desc_t   desc,
    input  wire logic         desc_empty,
    output logic              desc_pop,
    input  wire logic         out_pop,
    output logic              out_empty,
    output sefr_pkg::event_t  out_event
);
    import sefr_pkg::*;

    logic [1:0] step_reg;
    logic [1:0] step_next;
    logic [1:0] base;
    logic [1:0] last_idx;
    logic       emit;
    logic       outq_full;
    event_t     cur;
    event_t     mapped;
    logic [15:0] p_in;
    logic [16:0] p_sum;

    event_t                outq [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] owr_reg;
    logic [OUTQ_PTR_W-1:0] ord_reg;
    logic [OUTQ_CNT_W-1:0] ocnt_reg;
    logic [OUTQ_CNT_W-1:0] ocnt_next;
    logic                  out_fire;

    assign base     = desc.start ? 2'd2 : 2'd0;
    assign last_idx = base + {1'b0, desc.pen_lift};

    // pressure compensation, then clip
    assign p_in  = cfg.pressure_zero_mode ? 16'd0 : desc.value[15:0];
    assign p_sum = (p_in > PRESSURE_FLOOR)
                   ? ({1'b0, p_in} + 17'(cfg.pressure_offset)) : {1'b0, p_in};

    always_comb
    begin
        mapped.etype = desc.etype;
        mapped.code  = desc.code;
        mapped.value = desc.value;
        mapped.last  = 1'b1;
        if (desc.is_abs)
        begin
            mapped.value = {16'd0, desc.value[15:0]};
            if (desc.code == CODE_PRESSURE)
            begin
                mapped.value = (p_sum > {1'b0, PRESSURE_MAX})
                               ? {16'd0, PRESSURE_MAX} : {15'd0, p_sum};
            end
            else if (desc.code == CODE_Y)
            begin
                mapped.code  = CODE_X;
                mapped.value = {16'd0, Y_MIRROR - desc.value[15:0]};
            end
            else if (desc.code == CODE_X)
            begin
                mapped.code = CODE_Y;
            end
        end
    end

    always_comb
    begin
        if (desc.start && step_reg == 2'd0)
        begin
            cur.etype = EV_KEY;
            cur.code  = CODE_PEN;
            cur.value = 32'd1;
        end
        else if (desc.start && step_reg == 2'd1)
        begin
            cur.etype = EV_SYNC;
            cur.code  = 16'd0;
            cur.value = 32'd0;
        end
        else if (desc.pen_lift && step_reg == base)
        begin
            // pen lifted: release touch first
            cur.etype = EV_KEY;
            cur.code  = CODE_TOUCH;
            cur.value = 32'd0;
        end
        else
        begin
            cur.etype = mapped.etype;
            cur.code  = mapped.code;
            cur.value = mapped.value;
        end
        cur.last = (step_reg == last_idx);
    end

    assign emit     = !desc_empty && !outq_full;
    assign desc_pop = emit && cur.last;

    always_comb
    begin
        step_next = step_reg;
        if (emit)
        begin
            step_next = cur.last ? 2'd0 : step_reg + 2'd1;
        end
    end

    assign outq_full = (ocnt_reg == OUTQ_CNT_W'(OUTQ_DEPTH));
    assign out_empty = (ocnt_reg == '0);
    assign out_fire  = out_pop && !out_empty;
    assign out_event = outq[ord_reg];

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (emit && !out_fire)
        begin
            ocnt_next = ocnt_reg + OUTQ_CNT_W'(1);
        end
        else if (out_fire && !emit)
        begin
            ocnt_next = ocnt_reg - OUTQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            owr_reg  <= '0;
            ord_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
            ocnt_reg <= ocnt_next;
            if (emit)
            begin
                owr_reg <= owr_reg + OUTQ_PTR_W'(1);
            end
            if (out_fire)
            begin
                ord_reg <= ord_reg + OUTQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            outq[owr_reg] <= cur;
        end
    end

endmodule

`default_nettype wire
